>>> rtl/lspm_pkg.sv
package lspm_pkg;

	localparam int DEF_POOL_SIZE = 256;
	localparam int ITEM_W        = 8;
	localparam int ITEM_SPAN     = 1 << ITEM_W;
	localparam int COUNT_OUT_W   = 9;
	localparam int STATUS_W      = 2;

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_code_t;

	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

	typedef struct packed {
		req_code_t         req_type;
		logic [ITEM_W-1:0] item;
	} req_t;

	typedef struct packed {
		logic [ITEM_W-1:0]      popped_item;
		logic [STATUS_W-1:0]    status;
		logic [ITEM_W-1:0]      top_item;
		logic                   list_empty;
		logic [COUNT_OUT_W-1:0] item_count;
	} rsp_t;

	typedef struct packed {
		logic              set;
		logic              clr;
		logic              clear_all;
		logic [ITEM_W-1:0] idx;
	} member_cmd_t;

endpackage

>>> rtl/lspm_ram.sv
module lspm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lspm_member.sv
module lspm_member #(
	parameter int DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lspm_pkg::member_cmd_t               cmd,
	input  logic [lspm_pkg::ITEM_W-1:0]         look_idx,
	output logic                                hit
);

	import lspm_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [DEPTH-1:0] bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (cmd.clear_all) begin
			bits_q <= '0;
		end else if (cmd.set) begin
			bits_q[cmd.idx[AW-1:0]] <= 1'b1;
		end else if (cmd.clr) begin
			bits_q[cmd.idx[AW-1:0]] <= 1'b0;
		end
	end

	assign hit = (32'(look_idx) < DEPTH) && bits_q[look_idx[AW-1:0]];

endmodule

>>> rtl/linked_stack_pool_manager.sv
// channel  | signals                       | payload
// req      | req_valid / req_ready         | req (req_type, item)
// rsp      | rsp_valid / rsp_ready         | rsp (popped_item, status, top_item,
//          |                               |      list_empty, item_count)
//
// every request runs an accept step that checks membership and reads (or, for a
// push, writes) the link memories, then an execute step that updates neighbor
// links and the head registers; a pop or remove must see the item's links from
// the registered read before it can patch the neighbors, and a push writes the
// prev memory twice when the list is not empty
// a finished response sits in the output register; the next request is taken
// while it waits, and its execute step holds until the register is free
// reset clears the membership bits, head, tail and count at once; no sweep
module linked_stack_pool_manager #(
	parameter int POOL_SIZE = lspm_pkg::DEF_POOL_SIZE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lspm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lspm_pkg::rsp_t rsp
);

	import lspm_pkg::*;

	localparam int MEM_DEPTH = (POOL_SIZE < ITEM_SPAN) ? POOL_SIZE : ITEM_SPAN;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int LW        = $clog2(POOL_SIZE + 1);
	localparam int CW        = $clog2(MEM_DEPTH + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SIZE);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t        state_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	req_t          req_s1;
	logic          ok_s1;
	logic [LW-1:0] tgt_s1;

	logic accept;
	logic fire;
	logic head_valid;
	logic in_pool;
	logic member_hit;
	logic push_ok;
	logic pop_ok;
	logic rm_ok;

	logic [LW-1:0] nx_rd;
	logic [LW-1:0] pv_rd;

	logic          nwe, pwe;
	logic [AW-1:0] nwaddr, pwaddr;
	logic [LW-1:0] nwdata, pwdata;
	logic          ex_nwe, ex_pwe;
	logic [AW-1:0] ex_nwaddr, ex_pwaddr;
	logic [LW-1:0] ex_nwdata, ex_pwdata;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	member_cmd_t mcmd_ex;
	member_cmd_t mcmd;

	logic [LW-1:0]       head_d;
	logic [LW-1:0]       tail_d;
	logic [CW-1:0]       count_d;
	logic [STATUS_W-1:0] status_d;
	logic [ITEM_W-1:0]   popped_d;
	logic                unlink;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign fire       = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign head_valid = (head_q != NULL_LINK);
	assign in_pool    = (32'(req.item) < POOL_SIZE);

	lspm_member #(.DEPTH(MEM_DEPTH)) u_member (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mcmd),
		.look_idx (req.item),
		.hit      (member_hit)
	);

	assign push_ok = (req.req_type == REQ_PUSH) && in_pool && !member_hit;
	assign pop_ok  = (req.req_type == REQ_POP) && head_valid;
	assign rm_ok   = (req.req_type == REQ_REMOVE) && member_hit;
	assign rd_en   = accept && (pop_ok || rm_ok);
	assign rd_addr = (req.req_type == REQ_POP) ? head_q[AW-1:0] : req.item[AW-1:0];

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		status_d  = ST_DONE;
		popped_d  = '0;
		unlink    = 1'b0;
		ex_nwe    = 1'b0;
		ex_nwaddr = tgt_s1[AW-1:0];
		ex_nwdata = NULL_LINK;
		ex_pwe    = 1'b0;
		ex_pwaddr = tgt_s1[AW-1:0];
		ex_pwdata = NULL_LINK;
		mcmd_ex   = '0;
		mcmd_ex.idx = ITEM_W'(tgt_s1);
		unique case (req_s1.req_type)
			REQ_PUSH: begin
				if (ok_s1) begin
					if (head_q != NULL_LINK) begin
						ex_pwe    = 1'b1;
						ex_pwaddr = head_q[AW-1:0];
						ex_pwdata = tgt_s1;
					end else begin
						tail_d = tgt_s1;
					end
					head_d      = tgt_s1;
					count_d     = count_q + 1'b1;
					mcmd_ex.set = 1'b1;
				end else begin
					status_d = ST_MISMATCH;
				end
			end
			REQ_POP: begin
				if (ok_s1) begin
					popped_d = ITEM_W'(tgt_s1);
					unlink   = 1'b1;
				end else begin
					status_d = ST_EMPTY;
				end
			end
			REQ_REMOVE: begin
				if (ok_s1) begin
					unlink = 1'b1;
				end else begin
					status_d = ST_MISMATCH;
				end
			end
			REQ_CLEAR: begin
				head_d            = NULL_LINK;
				tail_d            = NULL_LINK;
				count_d           = '0;
				mcmd_ex.clear_all = 1'b1;
			end
			default: begin
			end
		endcase
		if (unlink) begin
			priority if (tgt_s1 == head_q) begin
				head_d = nx_rd;
				if (nx_rd == NULL_LINK) begin
					tail_d = NULL_LINK;
				end else begin
					ex_pwe    = 1'b1;
					ex_pwaddr = nx_rd[AW-1:0];
					ex_pwdata = NULL_LINK;
				end
			end else if (tgt_s1 == tail_q) begin
				tail_d = pv_rd;
				if (pv_rd != NULL_LINK) begin
					ex_nwe    = 1'b1;
					ex_nwaddr = pv_rd[AW-1:0];
					ex_nwdata = NULL_LINK;
				end
			end else if ((pv_rd != NULL_LINK) && (nx_rd != NULL_LINK)) begin
				ex_nwe    = 1'b1;
				ex_nwaddr = pv_rd[AW-1:0];
				ex_nwdata = nx_rd;
				ex_pwe    = 1'b1;
				ex_pwaddr = nx_rd[AW-1:0];
				ex_pwdata = pv_rd;
			end else begin
			end
			mcmd_ex.clr = 1'b1;
			if (count_q != '0) begin
				count_d = count_q - 1'b1;
			end
		end
	end

	assign mcmd = fire ? mcmd_ex : '0;

	// the new item's own links go in during the accept cycle
	always_comb begin
		if (accept && push_ok) begin
			nwe    = 1'b1;
			nwaddr = req.item[AW-1:0];
			nwdata = head_q;
			pwe    = 1'b1;
			pwaddr = req.item[AW-1:0];
			pwdata = NULL_LINK;
		end else begin
			nwe    = fire && ex_nwe;
			nwaddr = ex_nwaddr;
			nwdata = ex_nwdata;
			pwe    = fire && ex_pwe;
			pwaddr = ex_pwaddr;
			pwdata = ex_pwdata;
		end
	end

	lspm_ram #(.DEPTH(MEM_DEPTH), .WIDTH(LW)) u_next_mem (
		.clk   (clk),
		.we    (nwe),
		.waddr (nwaddr),
		.wdata (nwdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (nx_rd)
	);

	lspm_ram #(.DEPTH(MEM_DEPTH), .WIDTH(LW)) u_prev_mem (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwaddr),
		.wdata (pwdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (pv_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			ok_s1  <= push_ok || pop_ok || rm_ok;
			tgt_s1 <= (req.req_type == REQ_POP) ? head_q : LW'(req.item);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NULL_LINK;
			tail_q  <= NULL_LINK;
			count_q <= '0;
		end else if (fire) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.popped_item <= popped_d;
			rsp_q.status      <= status_d;
			rsp_q.top_item    <= (head_d != NULL_LINK) ? ITEM_W'(head_d) : '0;
			rsp_q.list_empty  <= (head_d == NULL_LINK);
			rsp_q.item_count  <= COUNT_OUT_W'(count_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
